// ===== src/rv32md_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32md_pkg
// Shared types and constants for the RV32M multiply/divide unit.
// ----------------------------------------------------------------------------
package rv32md_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned TAG_W    = 5;
  localparam int unsigned DIV_CELLS = XLEN;

  // RV32M operation codes
  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_t;

  // Word carried down the cell row.
  // Divide ops: r = partial remainder, q = dividend/quotient, d = divisor.
  // Multiply ops: r = high product, q = low product, d = signed correction.
  typedef struct packed {
    op_t               op;
    logic              neg;
    logic [TAG_W-1:0]  tag;
    logic [XLEN-1:0]   r;
    logic [XLEN-1:0]   q;
    logic [XLEN-1:0]   d;
  } stage_t;

endpackage

// ===== src/rv32md_if.sv =====
// ----------------------------------------------------------------------------
// rv32md_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface rv32md_req_if;
  import rv32md_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic [XLEN-1:0]   operand_a;
  logic [XLEN-1:0]   operand_b;
  logic [TAG_W-1:0]  dest_reg;

  modport source (output valid, op, operand_a, operand_b, dest_reg, input ready);
  modport sink   (input valid, op, operand_a, operand_b, dest_reg, output ready);
endinterface

interface rv32md_rsp_if;
  import rv32md_pkg::*;
  logic              valid;
  logic              ready;
  logic [XLEN-1:0]   result_value;
  logic [TAG_W-1:0]  result_reg;

  modport source (output valid, result_value, result_reg, input ready);
  modport sink   (input valid, result_value, result_reg, output ready);
endinterface

// ===== src/rv32md_cell.sv =====
// ----------------------------------------------------------------------------
// rv32md_cell
// One restoring-division step; multiply words pass through untouched.
// ----------------------------------------------------------------------------
module rv32md_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                valid_in,
  input  rv32md_pkg::stage_t  word_in,
  output logic                valid_out,
  output rv32md_pkg::stage_t  word_out
);
  import rv32md_pkg::*;

  logic [XLEN:0]   shifted;
  logic [XLEN:0]   trial;
  logic            fits;
  stage_t          word_next;

  // shift in next dividend bit, try subtracting the divisor
  always_comb begin
    shifted   = {word_in.r, word_in.q[XLEN-1]};
    trial     = shifted - {1'b0, word_in.d};
    fits      = ~trial[XLEN];
    word_next = word_in;
    if (word_in.op[2]) begin
      word_next.r = fits ? trial[XLEN-1:0] : shifted[XLEN-1:0];
      word_next.q = {word_in.q[XLEN-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_out <= word_next;
    end
  end

endmodule

// ===== src/rv32m_multiply_divide_unit.sv =====
// ----------------------------------------------------------------------------
// rv32m_multiply_divide_unit
// Pipelined RV32M execute unit: multiplies and divides for all eight ops.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one result per word, in order, through
// one operand-prep stage (32x32 multiplier and sign handling), a row of 32
// division cells that each retire one quotient bit, and one result-fixup
// stage. Multiply words ride along the cell row unchanged. The whole pipeline
// stalls only while a finished result is not taken.
module rv32m_multiply_divide_unit (
  input  logic   clk,
  input  logic   rst,
  rv32md_req_if.sink   req,
  rv32md_rsp_if.source rsp
);
  import rv32md_pkg::*;

  logic            en;
  logic            valid_chain [0:DIV_CELLS];
  stage_t          word_chain  [0:DIV_CELLS];

  op_t             op;
  logic            a_signed;
  logic            b_signed;
  logic            a_neg;
  logic            b_neg;
  logic [2*XLEN-1:0] prod;
  logic [XLEN-1:0] corr;
  logic [XLEN-1:0] mag_a;
  logic [XLEN-1:0] mag_b;
  stage_t          prep_next;

  logic [XLEN-1:0] pick;
  logic [XLEN-1:0] result_next;
  stage_t          last;

  assign en        = ~rsp.valid | rsp.ready;
  assign req.ready = en;

  // operand prep: signs, magnitudes, product and high-word correction
  always_comb begin
    op       = op_t'(req.op);
    a_signed = (op == OP_MULH) || (op == OP_MULHSU) || (op == OP_DIV) || (op == OP_REM);
    b_signed = (op == OP_MULH) || (op == OP_DIV) || (op == OP_REM);
    a_neg    = a_signed & req.operand_a[XLEN-1];
    b_neg    = b_signed & req.operand_b[XLEN-1];
    prod     = req.operand_a * req.operand_b;
    corr     = (a_neg ? req.operand_b : '0) + (b_neg ? req.operand_a : '0);
    mag_a    = a_neg ? (~req.operand_a + 1'b1) : req.operand_a;
    mag_b    = b_neg ? (~req.operand_b + 1'b1) : req.operand_b;

    prep_next.op  = op;
    prep_next.tag = req.dest_reg;
    if (op[2]) begin
      prep_next.r = '0;
      prep_next.q = mag_a;
      prep_next.d = mag_b;
      // remainder follows dividend sign; quotient sign only if divisor nonzero
      prep_next.neg = op[1] ? a_neg : ((a_neg ^ b_neg) & (|req.operand_b));
    end else begin
      prep_next.r   = prod[2*XLEN-1:XLEN];
      prep_next.q   = prod[XLEN-1:0];
      prep_next.d   = corr;
      prep_next.neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_chain[0] <= 1'b0;
    end else if (en) begin
      valid_chain[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_chain[0] <= prep_next;
    end
  end

  // row of division cells
  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    rv32md_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .valid_in  (valid_chain[i]),
      .word_in   (word_chain[i]),
      .valid_out (valid_chain[i+1]),
      .word_out  (word_chain[i+1])
    );
  end

  // result fixup
  always_comb begin
    last = word_chain[DIV_CELLS];
    pick = '0;
    unique case (last.op)
      OP_MUL:                       pick = last.q;
      OP_MULH, OP_MULHSU, OP_MULHU: pick = last.r - last.d;
      OP_DIV, OP_DIVU:              pick = last.q;
      OP_REM, OP_REMU:              pick = last.r;
      default:                      pick = last.q;
    endcase
    result_next = last.neg ? (~pick + 1'b1) : pick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= valid_chain[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.result_value <= result_next;
      rsp.result_reg   <= last.tag;
    end
  end

endmodule
